>>> hw/rtl/jkse_pkg.sv
package jkse_pkg;

  // Field widths fixed by the block's interface.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned KeyLenW = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_KEY_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_FIRST  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_LAST   = 2'd2;

  // Character codes the parser reacts to.
  localparam logic [ByteW-1:0] QUOTE_CHAR     = 8'h22;
  localparam logic [ByteW-1:0] BACKSLASH_CHAR = 8'h5C;
  localparam logic [ByteW-1:0] COLON_CHAR     = 8'h3A;
  localparam logic [ByteW-1:0] SPACE_CHAR     = 8'h20;
  localparam logic [ByteW-1:0] TAB_CHAR       = 8'h09;
  localparam logic [ByteW-1:0] CR_CHAR        = 8'h0D;

  typedef enum logic [KindW-1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] value_byte;
    kind_e            kind;
  } res_t;

  // Window control shared by every cell of the chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/jkse_if.sv
interface jkse_body_if;
  logic                        valid;
  logic                        ready;
  logic [jkse_pkg::ByteW-1:0]  body_byte;
  logic                        body_end;

  modport source (output valid, output body_byte, output body_end, input ready);
  modport sink (input valid, input body_byte, input body_end, output ready);
endinterface

interface jkse_res_if;
  logic                        valid;
  logic                        ready;
  logic [jkse_pkg::ByteW-1:0]  value_byte;
  logic [jkse_pkg::KindW-1:0]  kind;

  modport source (output valid, output value_byte, output kind, input ready);
  modport sink (input valid, input value_byte, input kind, output ready);
endinterface

interface jkse_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [jkse_pkg::CfgIdxW-1:0]  index;
  logic [jkse_pkg::CfgDatW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/json_key_string_extractor.sv
// JSON key string extractor.
//
// Body bytes arrive on body_i, one item per byte, with body_end marking the
// final byte of a body. Results leave on result_o: a value byte (kind 0), a
// "value complete" mark (kind 1) or a failure (kind 2), after which the
// consumer discards the value bytes it has already received. The key is set
// through cfg_i (index 0 key length, 1 key bytes 0 to 7, 2 key bytes 8 to 15)
// and the user writes it only while the block is idle, which the block itself
// does not enforce; cfg_i is always ready.
// One body byte is taken every cycle while body_i.ready is high. A result is
// registered in the output queue before it appears on result_o. The needle
// search runs in a chain of MAX_KEY_BYTES + 3 cells that shift the window and
// compare in parallel, so the window never holds up the stream. A two-entry
// output queue lets the block keep taking bytes while a result waits; if the
// receiver stalls long enough to fill it, body_i.ready drops until one entry
// is taken. Reset clears the key to zero length, empties the window and the
// output queue and starts a fresh needle search.
module json_key_string_extractor #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jkse_body_if.sink   body_i,
  jkse_res_if.source  result_o,
  jkse_cfg_if.sink    cfg_i
);

  localparam int unsigned Depth = MAX_KEY_BYTES + 3;
  localparam int unsigned KW    = jkse_pkg::KeyLenW;
  localparam int unsigned BW    = jkse_pkg::ByteW;

  // Configuration registers.
  logic [KW-1:0]                  key_length_q;
  logic [jkse_pkg::CfgDatW-1:0]   key_first_q, key_last_q;
  logic [2*jkse_pkg::CfgDatW-1:0] key_all;
  logic                           cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;
  assign key_all     = {key_last_q, key_first_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= '0;
      key_first_q  <= '0;
      key_last_q   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        jkse_pkg::REG_KEY_LENGTH: key_length_q <= cfg_i.data[KW-1:0];
        jkse_pkg::REG_KEY_FIRST:  key_first_q  <= cfg_i.data;
        jkse_pkg::REG_KEY_LAST:   key_last_q   <= cfg_i.data;
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // Effective key length and needle length (quote, key, quote, colon).
  logic [KW-1:0] klen, nlen;

  assign klen = (key_length_q > KW'(MAX_KEY_BYTES)) ? KW'(MAX_KEY_BYTES) : key_length_q;
  assign nlen = klen + KW'(3);

  // Input handshake and the parse sequencer.
  logic                 body_acc;
  logic                 match;
  logic                 res_valid;
  jkse_pkg::res_t       res;
  jkse_pkg::cell_ctrl_t cell_ctrl;
  logic                 skid_v_q;

  assign body_i.ready = !skid_v_q;
  assign body_acc     = body_i.valid && body_i.ready;

  jkse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (body_acc),
    .body_byte_i (body_i.body_byte),
    .body_end_i  (body_i.body_end),
    .match_i     (match),
    .cell_ctrl_o (cell_ctrl),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Window chain. Cell 0 holds the newest byte; each cell compares the byte
  // it is about to take against the needle byte that lines up with it.
  // Cell 0 must see the colon, cell 1 the closing quote, the next klen cells
  // the key in reverse, and cell nlen-1 the opening quote.
  logic [BW-1:0]    cell_byte [Depth];
  logic [Depth-1:0] cell_valid;
  logic [Depth-1:0] cell_ok;

  for (genvar j = 0; j < Depth; j++) begin : g_cell
    logic [BW-1:0] prev_byte, exp_byte;
    logic          prev_valid;

    if (j == 0) begin : g_head
      assign prev_byte  = body_i.body_byte;
      assign prev_valid = 1'b1;
      assign exp_byte   = jkse_pkg::COLON_CHAR;
    end else begin : g_link
      assign prev_byte  = cell_byte[j-1];
      assign prev_valid = cell_valid[j-1];
      if (j == 1) begin : g_close
        assign exp_byte = jkse_pkg::QUOTE_CHAR;
      end else begin : g_key
        logic [KW-1:0] kidx;
        assign kidx     = klen + KW'(1) - KW'(j);
        assign exp_byte = (KW'(j) == nlen - KW'(1)) ? jkse_pkg::QUOTE_CHAR
                                                      : key_all[{kidx[3:0], 3'b000} +: BW];
      end
    end

    jkse_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .prev_byte_i  (prev_byte),
      .prev_valid_i (prev_valid),
      .exp_byte_i   (exp_byte),
      .used_i       (KW'(j) < nlen),
      .byte_o       (cell_byte[j]),
      .valid_o      (cell_valid[j]),
      .ok_o         (cell_ok[j])
    );
  end

  assign match = &cell_ok;

  // Two-entry output queue: head drives the port, skid catches a result
  // produced while the head is stalled.
  logic           head_v_q;
  jkse_pkg::res_t head_q, skid_q;
  logic           push, pop;

  assign push = body_acc && res_valid;
  assign pop  = head_v_q && result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!head_v_q) begin
        head_v_q <= push;
      end else if (pop) begin
        if (skid_v_q) begin
          skid_v_q <= push;
        end else begin
          head_v_q <= push;
        end
      end else if (push) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!head_v_q) begin
      if (push) begin
        head_q <= res;
      end
    end else if (pop) begin
      if (skid_v_q) begin
        head_q <= skid_q;
        if (push) begin
          skid_q <= res;
        end
      end else if (push) begin
        head_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign result_o.valid      = head_v_q;
  assign result_o.value_byte = head_q.value_byte;
  assign result_o.kind       = head_q.kind;

  // The skid entry is only ever filled behind a waiting head.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> head_v_q)
    else $error("output skid entry valid without head entry");

  // A final byte empties the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (body_acc && body_i.body_end) |=> (cell_valid == '0))
    else $error("window not cleared after final byte");

  // Filled cells always form a run starting at the newest entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ((cell_valid & (cell_valid + {{(Depth-1){1'b0}}, 1'b1})) == '0))
    else $error("window fill bits not contiguous");

  // Only value bytes carry a nonzero payload byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (head_v_q && (head_q.kind != jkse_pkg::KIND_BYTE))
                   |-> (head_q.value_byte == '0))
    else $error("status result carries a value byte");

  // A stalled head with an empty skid takes a new result into the skid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (head_v_q && !result_o.ready && !skid_v_q && push) |=> skid_v_q)
    else $error("result lost while output stalled");

endmodule

>>> hw/rtl/jkse_cell.sv
module jkse_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  jkse_pkg::cell_ctrl_t       ctrl_i,
  input  logic [jkse_pkg::ByteW-1:0] prev_byte_i,
  input  logic                       prev_valid_i,
  input  logic [jkse_pkg::ByteW-1:0] exp_byte_i,
  input  logic                       used_i,
  output logic [jkse_pkg::ByteW-1:0] byte_o,
  output logic                       valid_o,
  output logic                       ok_o
);

  logic [jkse_pkg::ByteW-1:0] byte_q, byte_d;
  logic                       valid_q, valid_d;

  // The match is judged on the contents after this cycle's shift.
  assign ok_o = !used_i || (prev_valid_i && (prev_byte_i == exp_byte_i));

  always_comb begin
    byte_d  = byte_q;
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      byte_d  = prev_byte_i;
      valid_d = prev_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

>>> hw/rtl/jkse_ctrl.sv
module jkse_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [jkse_pkg::ByteW-1:0] body_byte_i,
  input  logic                       body_end_i,
  input  logic                       match_i,
  output jkse_pkg::cell_ctrl_t       cell_ctrl_o,
  output logic                       res_valid_o,
  output jkse_pkg::res_t             res_o
);

  localparam logic [2:0] MODE_SEARCH  = 3'd0;
  localparam logic [2:0] MODE_SKIP_WS = 3'd1;
  localparam logic [2:0] MODE_VALUE   = 3'd2;
  localparam logic [2:0] MODE_ESCAPE  = 3'd3;
  localparam logic [2:0] MODE_IDLE    = 3'd4;

  logic [2:0] mode_q, mode_d;
  logic       is_quote, is_bslash, is_space;

  assign is_quote  = (body_byte_i == jkse_pkg::QUOTE_CHAR);
  assign is_bslash = (body_byte_i == jkse_pkg::BACKSLASH_CHAR);
  assign is_space  = (body_byte_i == jkse_pkg::SPACE_CHAR) ||
                     ((body_byte_i >= jkse_pkg::TAB_CHAR) && (body_byte_i <= jkse_pkg::CR_CHAR));

  always_comb begin
    mode_d            = mode_q;
    res_valid_o       = 1'b0;
    res_o.value_byte  = '0;
    res_o.kind        = jkse_pkg::KIND_BYTE;
    cell_ctrl_o.shift = 1'b0;
    cell_ctrl_o.clear = accept_i && body_end_i;
    if (accept_i) begin
      unique case (mode_q)
        MODE_SEARCH: begin
          cell_ctrl_o.shift = 1'b1;
          if (match_i) begin
            mode_d = MODE_SKIP_WS;
          end
          if (body_end_i) begin
            res_valid_o = 1'b1;
            res_o.kind  = jkse_pkg::KIND_FAIL;
          end
        end
        MODE_SKIP_WS: begin
          if (body_end_i) begin
            res_valid_o = 1'b1;
            res_o.kind  = jkse_pkg::KIND_FAIL;
          end else if (is_quote) begin
            mode_d = MODE_VALUE;
          end else if (!is_space) begin
            res_valid_o = 1'b1;
            res_o.kind  = jkse_pkg::KIND_FAIL;
            mode_d      = MODE_IDLE;
          end
        end
        MODE_VALUE: begin
          if (is_quote) begin
            res_valid_o = 1'b1;
            res_o.kind  = jkse_pkg::KIND_DONE;
            mode_d      = MODE_IDLE;
          end else if (body_end_i) begin
            res_valid_o = 1'b1;
            res_o.kind  = jkse_pkg::KIND_FAIL;
          end else if (is_bslash) begin
            mode_d = MODE_ESCAPE;
          end else begin
            res_valid_o      = 1'b1;
            res_o.value_byte = body_byte_i;
          end
        end
        MODE_ESCAPE: begin
          res_valid_o = 1'b1;
          if (body_end_i) begin
            res_o.kind = jkse_pkg::KIND_FAIL;
          end else begin
            res_o.value_byte = body_byte_i;
            mode_d           = MODE_VALUE;
          end
        end
        MODE_IDLE: begin
          mode_d = MODE_IDLE;
        end
        default: begin
          mode_d = MODE_SEARCH;
        end
      endcase
      // Any final byte re-arms the search.
      if (body_end_i) begin
        mode_d = MODE_SEARCH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEARCH;
    end else begin
      mode_q <= mode_d;
    end
  end

endmodule

>>> bench/tb_json_key_string_extractor.sv
`timescale 1ns / 100ps

// Self-checking bench for the JSON key string extractor.
// Body items flow in through a queue-fed driver, results are checked by a
// monitor against a cycle-free predictor of the parser, and the key is
// reprogrammed between phases while the block sits idle.
module tb_json_key_string_extractor;

  localparam int unsigned MAX_KEY   = 16;
  localparam int unsigned WIN_DEPTH = MAX_KEY + 3;
  localparam int unsigned LIMIT     = 200000;  // Cycles before the run is declared hung.
  localparam int unsigned DRAIN     = 8;       // Quiet cycles before a key write or the end.
  localparam int unsigned HOLD_LEN  = 60;      // Length of the long receiver hold-off.
  localparam int unsigned PHASE_LEN = 80;      // Minimum body items per configuration phase.

  typedef logic [jkse_pkg::ByteW-1:0] byte_t;

  // One body item as the driver offers it.
  typedef struct packed {
    byte_t data;
    logic  last;
  } body_item_t;

  // Parser modes of the predictor.
  typedef enum logic [2:0] {
    SEEK_NEEDLE,
    SKIP_BLANKS,
    IN_VALUE,
    AFTER_ESCAPE,
    IGNORE_REST
  } scan_mode_e;

  logic clk_i;
  logic rst_ni;

  jkse_body_if body_if ();
  jkse_res_if  res_if ();
  jkse_cfg_if  cfg_if ();

  json_key_string_extractor #(
    .MAX_KEY_BYTES(MAX_KEY)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .body_i  (body_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  // 4 ns clock.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Items waiting to be offered, and results the predictor says must come.
  body_item_t       pending_bytes [$];
  jkse_pkg::res_t   expected_results [$];

  // Predictor copy of the key registers and of the parser state.
  logic [jkse_pkg::KeyLenW-1:0] key_len_reg;
  logic [63:0]                  key_lo_reg;
  logic [63:0]                  key_hi_reg;
  scan_mode_e                   scan_mode;
  byte_t                        window_bytes [WIN_DEPTH];
  int unsigned                  window_count;

  // Handshake bookkeeping shared between the input side, the driver, the ready
  // generator and the stimulus thread.
  bit          body_taken;
  bit          quiet_tail;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned rx_hold_left;
  int unsigned hold_asked;
  int unsigned hold_served;

  // Run statistics.
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned items_accepted;
  int unsigned value_bytes_seen;
  int unsigned done_seen;
  int unsigned fail_seen;
  int unsigned input_stall_cycles;

  // Key length as the parser uses it: anything above the maximum saturates.
  function automatic int unsigned key_len_used();
    return (key_len_reg > MAX_KEY) ? MAX_KEY : int'(key_len_reg);
  endfunction

  // Byte i of the needle: quote, key bytes, quote, colon.
  function automatic byte_t needle_char(input int unsigned i, input int unsigned klen);
    if (i == 0) return jkse_pkg::QUOTE_CHAR;
    if (i <= klen) begin
      if (i - 1 < 8) return key_lo_reg[8*(i-1) +: 8];
      return key_hi_reg[8*(i-9) +: 8];
    end
    if (i == klen + 1) return jkse_pkg::QUOTE_CHAR;
    return jkse_pkg::COLON_CHAR;
  endfunction

  function automatic bit is_blank(input byte_t b);
    return (b == jkse_pkg::SPACE_CHAR) ||
           (b >= jkse_pkg::TAB_CHAR && b <= jkse_pkg::CR_CHAR);
  endfunction

  function automatic void rearm_search();
    scan_mode    = SEEK_NEEDLE;
    window_count = 0;
    foreach (window_bytes[k]) window_bytes[k] = '0;
  endfunction

  // Advances the parser by one body item. Returns 1 and fills r when the item
  // produces a result.
  function automatic bit extract_step(input body_item_t it, output jkse_pkg::res_t r);
    bit          got;
    bit          hit;
    int unsigned klen;
    int unsigned nlen;
    got          = 1'b0;
    r.value_byte = '0;
    r.kind       = jkse_pkg::KIND_BYTE;
    case (scan_mode)
      SEEK_NEEDLE: begin
        for (int k = WIN_DEPTH - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
        window_bytes[0] = it.data;
        if (window_count < WIN_DEPTH) window_count++;
        klen = key_len_used();
        nlen = klen + 3;
        hit  = (window_count >= nlen);
        for (int k = 0; k < nlen; k++) begin
          if (window_bytes[nlen-1-k] != needle_char(k, klen)) hit = 1'b0;
        end
        if (hit) scan_mode = SKIP_BLANKS;
        if (it.last) begin
          got    = 1'b1;
          r.kind = jkse_pkg::KIND_FAIL;
        end
      end
      SKIP_BLANKS: begin
        if (it.last) begin
          got    = 1'b1;
          r.kind = jkse_pkg::KIND_FAIL;
        end else if (it.data == jkse_pkg::QUOTE_CHAR) begin
          scan_mode = IN_VALUE;
        end else if (!is_blank(it.data)) begin
          got       = 1'b1;
          r.kind    = jkse_pkg::KIND_FAIL;
          scan_mode = IGNORE_REST;
        end
      end
      IN_VALUE: begin
        if (it.data == jkse_pkg::QUOTE_CHAR) begin
          got       = 1'b1;
          r.kind    = jkse_pkg::KIND_DONE;
          scan_mode = IGNORE_REST;
        end else if (it.last) begin
          got    = 1'b1;
          r.kind = jkse_pkg::KIND_FAIL;
        end else if (it.data == jkse_pkg::BACKSLASH_CHAR) begin
          scan_mode = AFTER_ESCAPE;
        end else begin
          got          = 1'b1;
          r.value_byte = it.data;
        end
      end
      AFTER_ESCAPE: begin
        got = 1'b1;
        if (it.last) begin
          r.kind = jkse_pkg::KIND_FAIL;
        end else begin
          r.value_byte = it.data;
          scan_mode    = IN_VALUE;
        end
      end
      default: begin
      end
    endcase
    // Any final byte starts a fresh search for the next body.
    if (it.last) rearm_search();
    return got;
  endfunction

  task automatic push_item(input byte_t b, input logic last);
    body_item_t it;
    it.data = b;
    it.last = last;
    pending_bytes.push_back(it);
  endtask

  // Queues one body. Most bodies are well formed around the current needle,
  // with random noise before and after; the rest are plain noise, bodies with
  // a missing opening quote, or bodies cut short at a random byte. A clean
  // body is always well formed and complete.
  task automatic add_body(input int unsigned value_len, input bit clean);
    byte_t       seq [$];
    byte_t       b;
    int unsigned klen;
    int unsigned roll;
    int unsigned cut;
    klen = key_len_used();
    roll = clean ? 50 : $urandom_range(0, 99);
    if (roll < 20) begin
      repeat ($urandom_range(1, 12)) begin
        b = byte_t'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) b = jkse_pkg::QUOTE_CHAR;
        seq.push_back(b);
      end
    end else begin
      repeat ($urandom_range(0, 5)) seq.push_back(byte_t'($urandom_range(0, 255)));
      for (int unsigned i = 0; i < klen + 3; i++) seq.push_back(needle_char(i, klen));
      repeat ($urandom_range(0, 3)) begin
        b = byte_t'($urandom_range(8, 13));
        seq.push_back((b == 8'd8) ? jkse_pkg::SPACE_CHAR : b);
      end
      if (roll < 30) begin
        // Something other than the opening quote where the value should start.
        b = byte_t'($urandom_range(0, 255));
        seq.push_back((is_blank(b) || b == jkse_pkg::QUOTE_CHAR) ? 8'h7B : b);
      end else begin
        seq.push_back(jkse_pkg::QUOTE_CHAR);
        repeat (value_len) begin
          b = byte_t'($urandom_range(0, 255));
          if (b == jkse_pkg::QUOTE_CHAR || $urandom_range(0, 9) == 0) begin
            seq.push_back(jkse_pkg::BACKSLASH_CHAR);
          end
          seq.push_back(b);
        end
        seq.push_back(jkse_pkg::QUOTE_CHAR);
      end
      repeat ($urandom_range(0, 4)) seq.push_back(byte_t'($urandom_range(0, 255)));
      if (roll >= 82 && seq.size() > 1) begin
        cut = $urandom_range(1, seq.size() - 1);
        while (seq.size() > cut) void'(seq.pop_back());
      end
    end
    foreach (seq[i]) push_item(seq[i], i == seq.size() - 1);
  endtask

  // Register write on the configuration channel; the predictor copy follows
  // at the edge where the write is taken.
  task automatic write_reg(input logic [jkse_pkg::CfgIdxW-1:0] idx,
                           input logic [jkse_pkg::CfgDatW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      jkse_pkg::REG_KEY_LENGTH: key_len_reg = val[jkse_pkg::KeyLenW-1:0];
      jkse_pkg::REG_KEY_FIRST:  key_lo_reg  = val;
      jkse_pkg::REG_KEY_LAST:   key_hi_reg  = val;
      default: begin
      end
    endcase
  endtask

  task automatic program_key(input logic [jkse_pkg::CfgDatW-1:0] len, input logic [63:0] lo,
                             input logic [63:0] hi);
    write_reg(jkse_pkg::REG_KEY_LENGTH, len);
    write_reg(jkse_pkg::REG_KEY_FIRST, lo);
    write_reg(jkse_pkg::REG_KEY_LAST, hi);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Sender pause: nothing more is offered until every queued item is taken
  // and every expected result has come back, then a few extra cycles cover
  // items that are still inside the block without a result of their own.
  task automatic wait_until_idle();
    while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // Hang guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("%0t: timeout with %0d items queued and %0d results outstanding", $realtime,
               pending_bytes.size(), expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Input side, sampled at the rising edge: an accepted item leaves the
  // queue and goes through the predictor.
  always @(posedge clk_i) begin
    body_item_t     it;
    jkse_pkg::res_t r;
    if (rst_ni) begin
      body_taken = body_if.valid && body_if.ready;
      if (body_if.valid && !body_if.ready) input_stall_cycles++;
      if (body_taken) begin
        it = pending_bytes.pop_front();
        items_accepted++;
        if (extract_step(it, r)) expected_results.push_back(r);
      end
    end
  end

  // Driver, updated at the falling edge. An offered item stays on the bus
  // until it is taken. Between items the sender may go quiet for a random
  // burst, except during the receiver hold-off, where it keeps pushing so the
  // block fills up, and in the quiet tail of the run.
  always @(negedge clk_i) begin
    logic       nxt_valid;
    body_item_t nxt;
    if (rst_ni && !(body_if.valid && !body_taken)) begin
      nxt_valid = 1'b0;
      nxt       = '0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending_bytes.size() > 0) begin
        if (!quiet_tail && rx_hold_left == 0 && $urandom_range(0, 9) == 0) begin
          tx_gap = $urandom_range(1, 15) - 1;
        end else begin
          nxt_valid = 1'b1;
          nxt       = pending_bytes[0];
        end
      end
      body_if.valid     <= nxt_valid;
      body_if.body_byte <= nxt.data;
      body_if.body_end  <= nxt.last;
    end
  end

  // Receiver ready, updated at the falling edge: random stall bursts, plus
  // one long hold-off on request from the stimulus thread.
  always @(negedge clk_i) begin
    logic nxt_ready;
    if (hold_asked != hold_served) begin
      hold_served++;
      rx_hold_left = HOLD_LEN;
    end
    nxt_ready = 1'b0;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
    end else if (rx_gap > 0) begin
      rx_gap--;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(1, 15) - 1;
    end else begin
      nxt_ready = 1'b1;
    end
    res_if.ready <= nxt_ready;
  end

  // Monitor: every taken result must match the oldest expectation.
  always @(posedge clk_i) begin
    jkse_pkg::res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual kind %0d byte 0x%02h",
                 $realtime, res_if.kind, res_if.value_byte);
      end else begin
        want = expected_results.pop_front();
        case (jkse_pkg::kind_e'(res_if.kind))
          jkse_pkg::KIND_BYTE: value_bytes_seen++;
          jkse_pkg::KIND_DONE: done_seen++;
          default:             fail_seen++;
        endcase
        if (res_if.kind != want.kind) begin
          error_count++;
          $display("%0t: kind mismatch, expected %0d, actual %0d", $realtime, want.kind,
                   res_if.kind);
        end
        if (res_if.value_byte != want.value_byte) begin
          error_count++;
          $display("%0t: value byte mismatch, expected 0x%02h, actual 0x%02h", $realtime,
                   want.value_byte, res_if.value_byte);
        end
      end
    end
  end

  // Stimulus thread.
  initial begin
    int unsigned phase_start;
    // Every input of the block starts at a known value.
    rst_ni            = 1'b0;
    body_if.valid     = 1'b0;
    body_if.body_byte = '0;
    body_if.body_end  = 1'b0;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = jkse_pkg::REG_KEY_LENGTH;
    cfg_if.data       = '0;
    key_len_reg       = '0;
    key_lo_reg        = '0;
    key_hi_reg        = '0;
    rearm_search();

    // Reset is held from time zero and released at a falling edge.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset key: zero length, so the needle is "":
    // A lone final byte: the body ends while still searching.
    push_item(8'h00, 1'b1);
    // The final byte is the one that completes the needle.
    push_item(jkse_pkg::QUOTE_CHAR, 1'b0);
    push_item(jkse_pkg::QUOTE_CHAR, 1'b0);
    push_item(jkse_pkg::COLON_CHAR, 1'b1);
    // Blanks before the value, an escaped quote, the byte extremes, and the
    // closing quote on the final byte.
    push_item(jkse_pkg::QUOTE_CHAR, 1'b0);
    push_item(jkse_pkg::QUOTE_CHAR, 1'b0);
    push_item(jkse_pkg::COLON_CHAR, 1'b0);
    push_item(jkse_pkg::SPACE_CHAR, 1'b0);
    push_item(jkse_pkg::TAB_CHAR, 1'b0);
    push_item(jkse_pkg::QUOTE_CHAR, 1'b0);
    push_item(jkse_pkg::BACKSLASH_CHAR, 1'b0);
    push_item(jkse_pkg::QUOTE_CHAR, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(jkse_pkg::QUOTE_CHAR, 1'b1);
    // Missing opening quote; the trailing final byte is then ignored.
    push_item(jkse_pkg::QUOTE_CHAR, 1'b0);
    push_item(jkse_pkg::QUOTE_CHAR, 1'b0);
    push_item(jkse_pkg::COLON_CHAR, 1'b0);
    push_item(8'h78, 1'b0);
    push_item(8'h7A, 1'b1);
    // The body ends on a backslash inside the value.
    push_item(jkse_pkg::QUOTE_CHAR, 1'b0);
    push_item(jkse_pkg::QUOTE_CHAR, 1'b0);
    push_item(jkse_pkg::COLON_CHAR, 1'b0);
    push_item(jkse_pkg::QUOTE_CHAR, 1'b0);
    push_item(8'h61, 1'b0);
    push_item(jkse_pkg::BACKSLASH_CHAR, 1'b1);
    wait_until_idle();

    // Random phases, each under its own key. The key is only touched here,
    // after the previous phase has fully drained.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: program_key(64'd16, '1, '1);
        1: program_key(64'd31, {$urandom, $urandom}, {$urandom, $urandom});
        2: program_key(64'd1, {$urandom, $urandom}, '0);
        3: program_key(64'd8, {$urandom, $urandom}, {$urandom, $urandom});
        4: program_key(64'd0, '0, '0);
        default: program_key({32'd0, $urandom_range(1, 16)}, {$urandom, $urandom},
                             {$urandom, $urandom});
      endcase
      // The final phase runs with no idling on either side.
      if (p == 5) quiet_tail = 1'b1;
      phase_start = pending_bytes.size() + items_accepted;
      if (p == 1) begin
        // Long receiver hold-off against a body with a long value, so the
        // output queue fills and the block must stall its input.
        hold_asked++;
        add_body(24, 1'b1);
      end
      while (pending_bytes.size() + items_accepted - phase_start < PHASE_LEN) begin
        add_body($urandom_range(0, 8), 1'b0);
      end
      wait_until_idle();
    end

    $display("Ran %0d body items over seven key settings: %0d value bytes, %0d complete,",
             items_accepted, value_bytes_seen, done_seen);
    $display("%0d failure results; input held off for %0d cycles, %0d mismatches.",
             fail_seen, input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
